/* sv/ordered_list_table_engine_unit_defines.svh */
// Assertion macros for the file that checks its own logic.
`ifndef ORDERED_LIST_TABLE_ENGINE_UNIT_DEFINES_SVH
`define ORDERED_LIST_TABLE_ENGINE_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define OLTE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define OLTE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/olte_pkg.sv */
package olte_pkg;

    typedef enum logic [1:0] {
        REQ_APPEND = 2'd0,
        REQ_READ   = 2'd1,
        REQ_FIND   = 2'd2,
        REQ_REMOVE = 2'd3
    } req_kind_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_RANGE     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        RD_NONE = 2'd0,
        RD_POS  = 2'd1,
        RD_NEXT = 2'd2,
        RD_SKIP = 2'd3
    } rd_sel_t;

    typedef enum logic [2:0] {
        S_IDLE     = 3'd0,
        S_DISPATCH = 3'd1,
        S_READ     = 3'd2,
        S_SCAN     = 3'd3,
        S_SHIFT    = 3'd4,
        S_RESP     = 3'd5
    } state_t;

    typedef struct packed {
        logic      accept;
        logic      do_append;
        logic      set_status;
        status_t   status_code;
        rd_sel_t   rd_sel;
        logic      ptr_load;
        logic      ptr_inc;
        logic      capture_read;
        logic      set_hit;
        logic      dec_count;
        logic      shift_write;
        logic      load_out;
    } dp_cmd_t;

    typedef struct packed {
        req_kind_t kind;
        logic      full;
        logic      pos_in_range;
        logic      match;
        logic      scan_last;
        logic      shift_done;
        logic      out_free;
    } dp_sts_t;

endpackage

/* sv/ordered_list_table_engine_unit.sv */
// Packed list of up to DEPTH words: append, read at index, find first match
// from a start index, and remove first match with the later entries moved down.
// One request is in work at a time; a new request is taken while the previous
// result still waits on the output register. Append goes from dispatch straight
// to the response state; read passes through a read state unless the index is
// out of range; find compares the entries one by one in the scan state, up to
// the entry count; remove follows the find with a shift state that moves each
// entry above the hit down by one place. A result held on the output register
// stalls the next request in its response state until the sink takes it.
// The find and remove loops are set by the entry memory: one read port and one
// write port, one access each per cycle. There is no clearing pass after reset.
`include "ordered_list_table_engine_unit_defines.svh"

module ordered_list_table_engine_unit
    import olte_pkg::*;
#(
    parameter int DEPTH         = 256,
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [31:0] s_value,
    input  logic [7:0]  s_position,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [31:0] m_read_value,
    output logic [7:0]  m_found_index,
    output logic [8:0]  m_entry_count
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    olte_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    olte_dp #(
        .DEPTH         (DEPTH),
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_req_type    (s_req_type),
        .s_value       (s_value),
        .s_position    (s_position),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_read_value  (m_read_value),
        .m_found_index (m_found_index),
        .m_entry_count (m_entry_count),
        .cmd           (cmd),
        .sts           (sts)
    );

    `OLTE_ASSERT_NOW(a_no_append_when_full, cmd.do_append, !sts.full,
        "append write on a full list")
    `OLTE_ASSERT_NOW(a_shift_in_range, cmd.shift_write, !sts.shift_done,
        "shift write past the entry count")
    `OLTE_ASSERT_NEXT(a_load_shows_result, cmd.load_out, m_valid,
        "loaded result not presented")
    `OLTE_ASSERT_NOW(a_fail_fields_zero, m_valid && (m_status != ST_OK),
        (m_read_value == 32'd0) && (m_found_index == 8'd0),
        "failed request carries nonzero data")

endmodule

/* sv/olte_ctrl.sv */
module olte_ctrl
    import olte_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.status_code = ST_OK;
        cmd.rd_sel      = RD_NONE;
        s_ready    = 1'b0;

        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (sts.kind)
                    REQ_APPEND: begin
                        if (sts.full) begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_FULL;
                        end else begin
                            cmd.do_append = 1'b1;
                        end
                        state_next = S_RESP;
                    end
                    REQ_READ: begin
                        if (sts.pos_in_range) begin
                            cmd.rd_sel = RD_POS;
                            state_next = S_READ;
                        end else begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_RANGE;
                            state_next      = S_RESP;
                        end
                    end
                    default: begin
                        if (sts.pos_in_range) begin
                            cmd.rd_sel   = RD_POS;
                            cmd.ptr_load = 1'b1;
                            state_next   = S_SCAN;
                        end else begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_NOT_FOUND;
                            state_next      = S_RESP;
                        end
                    end
                endcase
            end
            S_READ: begin
                cmd.capture_read = 1'b1;
                state_next       = S_RESP;
            end
            S_SCAN: begin
                if (sts.match) begin
                    cmd.set_hit = 1'b1;
                    if (sts.kind == REQ_REMOVE) begin
                        // prefetch the entry above the hit for the shift
                        cmd.dec_count = 1'b1;
                        cmd.rd_sel    = RD_NEXT;
                        state_next    = S_SHIFT;
                    end else begin
                        state_next = S_RESP;
                    end
                end else if (sts.scan_last) begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ST_NOT_FOUND;
                    state_next      = S_RESP;
                end else begin
                    cmd.rd_sel  = RD_NEXT;
                    cmd.ptr_inc = 1'b1;
                end
            end
            S_SHIFT: begin
                if (sts.shift_done) begin
                    state_next = S_RESP;
                end else begin
                    cmd.shift_write = 1'b1;
                    cmd.rd_sel      = RD_SKIP;
                    cmd.ptr_inc     = 1'b1;
                end
            end
            S_RESP: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* sv/olte_dp.sv */
module olte_dp
    import olte_pkg::*;
#(
    parameter int DEPTH         = 256,
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [1:0]  s_req_type,
    input  logic [31:0] s_value,
    input  logic [7:0]  s_position,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [31:0] m_read_value,
    output logic [7:0]  m_found_index,
    output logic [8:0]  m_entry_count,
    input  dp_cmd_t     cmd,
    output dp_sts_t     sts
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > 8) ? CW : 8;

    logic [ELEMENT_WIDTH-1:0] mem [DEPTH];

    req_kind_t                kind_reg;
    logic [ELEMENT_WIDTH-1:0] key_reg;
    logic [7:0]               pos_reg;
    logic [CW-1:0]            count_reg;
    logic [CW-1:0]            ptr_reg;
    status_t                  res_status_reg;
    logic [ELEMENT_WIDTH-1:0] res_rd_reg;
    logic [CW-1:0]            res_idx_reg;
    logic [ELEMENT_WIDTH-1:0] rdata_reg;

    logic                     m_valid_reg;
    logic [1:0]               m_status_reg;
    logic [31:0]              m_read_value_reg;
    logic [7:0]               m_found_index_reg;
    logic [8:0]               m_entry_count_reg;

    logic [95:0]              value_ext;
    logic [ELEMENT_WIDTH+31:0] rd_ext;
    logic [CW+7:0]            idx_ext;
    logic [CW+8:0]            cnt_ext;
    logic [PW-1:0]            pos_w;
    logic [PW-1:0]            count_w;
    logic [CW:0]              ptr_plus1;
    logic [CW:0]              ptr_plus2;
    logic                     mem_we;
    logic [AW-1:0]            mem_waddr;
    logic [ELEMENT_WIDTH-1:0] mem_wdata;
    logic                     mem_re;
    logic [AW-1:0]            mem_raddr;

    assign value_ext = {64'd0, s_value};
    assign rd_ext    = {32'd0, res_rd_reg};
    assign idx_ext   = {8'd0, res_idx_reg};
    assign cnt_ext   = {9'd0, count_reg};
    assign pos_w     = PW'(pos_reg);
    assign count_w   = PW'(count_reg);
    assign ptr_plus1 = {1'b0, ptr_reg} + (CW+1)'(1);
    assign ptr_plus2 = {1'b0, ptr_reg} + (CW+1)'(2);

    assign sts.kind         = kind_reg;
    assign sts.full         = (count_reg == CW'(DEPTH));
    assign sts.pos_in_range = (pos_w < count_w);
    assign sts.match        = (rdata_reg == key_reg);
    assign sts.scan_last    = (ptr_plus1 >= {1'b0, count_reg});
    assign sts.shift_done   = (ptr_reg >= count_reg);
    assign sts.out_free     = !m_valid_reg || m_ready;

    // memory port select
    always_comb begin
        mem_we    = cmd.do_append || cmd.shift_write;
        mem_waddr = cmd.do_append ? count_reg[AW-1:0] : ptr_reg[AW-1:0];
        mem_wdata = cmd.do_append ? key_reg : rdata_reg;
        mem_re    = 1'b1;
        case (cmd.rd_sel)
            RD_POS:  mem_raddr = pos_w[AW-1:0];
            RD_NEXT: mem_raddr = ptr_plus1[AW-1:0];
            RD_SKIP: mem_raddr = ptr_plus2[AW-1:0];
            default: begin
                mem_raddr = ptr_reg[AW-1:0];
                mem_re    = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_re) begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    // request and working registers
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            kind_reg       <= req_kind_t'(s_req_type);
            key_reg        <= value_ext[ELEMENT_WIDTH-1:0];
            pos_reg        <= s_position;
            res_status_reg <= ST_OK;
            res_rd_reg     <= '0;
            res_idx_reg    <= '0;
        end
        if (cmd.do_append) begin
            res_idx_reg <= count_reg;
        end
        if (cmd.set_status) begin
            res_status_reg <= cmd.status_code;
        end
        if (cmd.capture_read) begin
            res_rd_reg <= rdata_reg;
        end
        if (cmd.set_hit) begin
            res_idx_reg <= ptr_reg;
        end
        if (cmd.ptr_load) begin
            ptr_reg <= pos_w[CW-1:0];
        end else if (cmd.ptr_inc) begin
            ptr_reg <= ptr_plus1[CW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.do_append) begin
            count_reg <= count_reg + CW'(1);
        end else if (cmd.dec_count) begin
            count_reg <= count_reg - CW'(1);
        end
    end

    // output register: hold the transaction until the sink takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_status_reg      <= res_status_reg;
            m_read_value_reg  <= rd_ext[31:0];
            m_found_index_reg <= idx_ext[7:0];
            m_entry_count_reg <= cnt_ext[8:0];
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_read_value  = m_read_value_reg;
    assign m_found_index = m_found_index_reg;
    assign m_entry_count = m_entry_count_reg;

endmodule
